// ===== design/fpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants
// Beat types, configuration image, sequencer commands and fixed-point limits
// for the filtered PID controller.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int W_FRAC     = 15;
    localparam int DIV_N      = 48;                 // dividend width of the divider
    localparam int DIV_D      = 32;                 // divisor width
    localparam int DIV_CNT_W  = $clog2(DIV_N + 1);
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 28;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam logic [16:0] ONE_W = 17'd32768;

    localparam logic signed [33:0] YAW_HALF = 34'sd180 <<< FRAC_BITS;
    localparam logic signed [33:0] YAW_FULL = 34'sd360 <<< FRAC_BITS;

    localparam logic signed [49:0] I48_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] I48_MIN = -50'sd140737488355328;

    // request types
    localparam logic [1:0] REQ_PLAIN = 2'd0;
    localparam logic [1:0] REQ_YAW   = 2'd1;
    localparam logic [1:0] REQ_RATE  = 2'd2;

    // integrate modes
    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_FULL   = 2'd1;
    localparam logic [1:0] MODE_WEIGHT = 2'd2;

    // register indexes
    localparam logic [2:0] REG_GAIN_P  = 3'd0;
    localparam logic [2:0] REG_GAIN_I  = 3'd1;
    localparam logic [2:0] REG_GAIN_D  = 3'd2;
    localparam logic [2:0] REG_I_LIMIT = 3'd3;
    localparam logic [2:0] REG_E_LIMIT = 3'd4;
    localparam logic [2:0] REG_R_LIMIT = 3'd5;
    localparam logic [2:0] REG_WEIGHTS = 3'd6;
    localparam logic [2:0] REG_ENABLE  = 3'd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] measurement;
        logic signed [31:0] reference;
        logic [31:0]        now_time;
        logic [31:0]        nominal_period;
        logic [1:0]         integrate_mode;
        logic               derivative_on_error;
        logic signed [31:0] measured_rate;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               saturated;
        logic               was_reset;
    } t_out_item;

    typedef struct packed {
        logic [25:0] gain_p;
        logic [22:0] gain_i;
        logic [22:0] gain_d;
        logic [25:0] integral_limit;
        logic [25:0] error_limit;
        logic [25:0] rate_limit;
        logic [63:0] smoothing_weights;
        logic        enable;
    } t_cfg;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_REF_A,
        CMD_REF_B,
        CMD_REF_C,
        CMD_ERR,
        CMD_EK_A,
        CMD_EK_B,
        CMD_DNUM,
        CMD_DRAW,
        CMD_D_A,
        CMD_D_B,
        CMD_INT_A,
        CMD_INT_B,
        CMD_INT_C,
        CMD_INT_D,
        CMD_INT_E,
        CMD_INT_F,
        CMD_AW_A,
        CMD_AW_B,
        CMD_AW_C,
        CMD_AW_D,
        CMD_AW_E,
        CMD_OUT_A,
        CMD_OUT_B,
        CMD_OUT_C,
        CMD_FIN
    } t_cmd;

    typedef struct packed {
        logic enabled;
        logic div_done;
        logic wind;
    } t_status;

endpackage

// ===== design/fpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_div: shared restoring divider
// Unsigned quotient, one bit per cycle while busy; done pulses for one cycle as the last bit lands.
// ----------------------------------------------------------------------------
module fpc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fpc_pkg::DIV_N-1:0] i_dividend,
    input  logic [fpc_pkg::DIV_D-1:0] i_divisor,
    output logic                      o_done,
    output logic [fpc_pkg::DIV_N-1:0] o_quotient
);
    import fpc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D-1:0]     r_rem;
    logic [DIV_N-1:0]     r_quo;
    logic [DIV_D-1:0]     r_den;
    logic [DIV_D:0]       trial;
    logic                 fits;

    assign trial = {r_rem, r_quo[DIV_N-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DIV_D'(trial - {1'b0, r_den}) : trial[DIV_D-1:0];
            r_quo <= {r_quo[DIV_N-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/fpc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_datapath: PID arithmetic
// History registers, one shared registered multiplier and the divider,
// stepped by commands from the controller.
// ----------------------------------------------------------------------------
module fpc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpc_pkg::t_cfg      i_cfg,
    input  fpc_pkg::t_cmd      i_cmd,
    input  fpc_pkg::t_in_item  i_in_data,
    output fpc_pkg::t_status   o_status,
    output fpc_pkg::t_out_item o_out_data
);
    import fpc_pkg::*;

    function automatic logic signed [16:0] sat_w(input logic [15:0] x);
        logic [16:0] v;
        v = {1'b0, x};
        return (v > ONE_W) ? $signed(ONE_W) : $signed(v);
    endfunction

    // history
    logic signed [47:0] r_int;
    logic signed [26:0] r_lerr, r_lrate;
    logic signed [31:0] r_lref, r_lmeas;
    logic [31:0]        r_ltime;

    // step working registers
    t_in_item              r_in;
    logic [31:0]           r_gap;
    logic                  r_rst;
    logic signed [MUL_P_W-1:0] r_prod, r_acc;
    logic signed [31:0]    r_r;
    logic signed [26:0]    r_e, r_ek, r_raw, r_d, r_iterm;
    logic                  r_nneg, r_nzero, r_ineg, r_wind;
    logic signed [43:0]    r_inc, r_incw;
    logic [47:0]           r_amag;
    t_out_item             r_st, r_out;

    logic signed [16:0] w0, w1, w2, w3;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod_n;
    logic signed [MUL_P_W:0]   acc_sum;

    logic [31:0]        gap_n;
    logic               rst_n_step;
    logic signed [33:0] e0, e1, e2, elim;
    logic signed [33:0] num;
    logic [31:0]        nmag;
    logic [25:0]        q_c;
    logic signed [26:0] raw_div, raw_ext;
    logic signed [32:0] mneg, rlim;
    logic signed [63:0] s64;
    logic signed [43:0] isel;
    logic signed [49:0] s50;
    logic [55:0]        mag56;
    logic               wind_n;
    logic [25:0]        iterm_mag;
    logic signed [MUL_P_W:0] out_s;

    logic              div_start, div_done;
    logic [DIV_N-1:0]  div_dnd, div_quo;
    logic [DIV_D-1:0]  div_dsr;

    assign w0 = sat_w(i_cfg.smoothing_weights[15:0]);
    assign w1 = sat_w(i_cfg.smoothing_weights[31:16]);
    assign w2 = sat_w(i_cfg.smoothing_weights[47:32]);
    assign w3 = sat_w(i_cfg.smoothing_weights[63:48]);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd)
            CMD_REF_A: begin mul_a = MUL_A_W'(r_lref);      mul_b = MUL_B_W'(w2); end
            CMD_REF_B: begin
                mul_a = MUL_A_W'(r_in.reference);
                mul_b = MUL_B_W'($signed(ONE_W) - w2);
            end
            CMD_ERR:   begin mul_a = MUL_A_W'(r_lerr);      mul_b = MUL_B_W'(w0); end
            CMD_EK_A:  begin mul_a = MUL_A_W'(r_e);  mul_b = MUL_B_W'($signed(ONE_W) - w0); end
            CMD_DRAW:  begin mul_a = MUL_A_W'(r_lrate);     mul_b = MUL_B_W'(w1); end
            CMD_D_A:   begin mul_a = MUL_A_W'(r_raw); mul_b = MUL_B_W'($signed(ONE_W) - w1); end
            CMD_INT_A: begin mul_a = $signed({1'b0, r_gap}); mul_b = MUL_B_W'(r_ek); end
            CMD_INT_C: begin
                mul_a = $signed({11'b0, r_inc[21:0]});
                mul_b = MUL_B_W'(w3);
            end
            CMD_INT_D: begin
                mul_a = MUL_A_W'($signed(r_inc[43:22]));
                mul_b = MUL_B_W'(w3);
            end
            CMD_AW_B:  begin
                mul_a = $signed({9'b0, r_amag[47:24]});
                mul_b = $signed({5'b0, i_cfg.gain_i});
            end
            CMD_AW_C:  begin
                mul_a = $signed({9'b0, r_amag[23:0]});
                mul_b = $signed({5'b0, i_cfg.gain_i});
            end
            CMD_OUT_A: begin mul_a = MUL_A_W'(r_ek); mul_b = $signed({2'b0, i_cfg.gain_p}); end
            CMD_OUT_B: begin mul_a = MUL_A_W'(r_d);  mul_b = $signed({5'b0, i_cfg.gain_d}); end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod_n  = mul_a * mul_b;
    assign acc_sum = $signed({r_acc[MUL_P_W-1], r_acc}) + $signed({r_prod[MUL_P_W-1], r_prod});

    // time gap and reset-step test
    assign gap_n      = i_in_data.now_time - r_ltime;
    assign rst_n_step = {1'b0, gap_n} > {i_in_data.nominal_period, 1'b0};

    // error: wrap for yaw, then clamp
    always_comb begin
        e0   = 34'(r_r) - 34'(r_in.measurement);
        e1   = (r_in.req_type == REQ_YAW && e0 > YAW_HALF) ? e0 - YAW_FULL : e0;
        e2   = (r_in.req_type == REQ_YAW && e1 < -YAW_HALF) ? e1 + YAW_FULL : e1;
        elim = $signed({8'b0, i_cfg.error_limit});
        if (e2 > elim)       e2 = elim;
        else if (e2 < -elim) e2 = -elim;
    end

    // derivative numerator
    always_comb begin
        if (r_in.derivative_on_error)
            num = 34'(r_ek) - 34'(r_lerr);
        else
            num = 34'(r_lmeas) - 34'(r_in.measurement);
        nmag = num[33] ? 32'(-num) : num[31:0];
    end

    // raw derivative
    always_comb begin
        if (r_nzero)
            q_c = '0;
        else if (r_gap == '0 || div_quo > {22'b0, i_cfg.rate_limit})
            q_c = i_cfg.rate_limit;
        else
            q_c = div_quo[25:0];
        raw_div = r_nneg ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
        mneg    = -33'(r_in.measured_rate);
        rlim    = $signed({7'b0, i_cfg.rate_limit});
        if (mneg > rlim)       raw_ext = 27'(rlim);
        else if (mneg < -rlim) raw_ext = 27'(-rlim);
        else                   raw_ext = 27'(mneg);
    end

    // integration
    always_comb begin
        s64  = ($signed({{3{r_prod[MUL_P_W-1]}}, r_prod}) <<< 22)
             + $signed({{3{r_acc[MUL_P_W-1]}}, r_acc});
        isel = (r_in.integrate_mode == MODE_WEIGHT) ? r_incw : r_inc;
        s50  = 50'(r_int) + 50'(isel);
        if (s50 > I48_MAX)      s50 = I48_MAX;
        else if (s50 < I48_MIN) s50 = I48_MIN;
    end

    // anti-windup magnitude
    assign mag56     = {r_acc[47:0], 8'b0} + {24'b0, r_prod[47:16]};
    assign wind_n    = mag56 > {30'b0, i_cfg.integral_limit};
    assign iterm_mag = wind_n ? i_cfg.integral_limit : mag56[25:0];

    assign out_s = (acc_sum >>> FRAC_BITS) + (MUL_P_W+1)'(r_iterm);

    // divider requests
    always_comb begin
        div_start = 1'b0;
        div_dnd   = {nmag, 16'b0};
        div_dsr   = r_gap;
        if (i_cmd == CMD_DNUM) begin
            div_start = 1'b1;
        end else if (i_cmd == CMD_AW_D) begin
            div_start = wind_n;
            div_dnd   = {6'b0, i_cfg.integral_limit, 16'b0};
            div_dsr   = {9'b0, i_cfg.gain_i};
        end
    end

    fpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dnd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // history state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int   <= '0;
            r_lerr  <= '0;
            r_lrate <= '0;
            r_lref  <= '0;
            r_lmeas <= '0;
            r_ltime <= '0;
        end else begin
            case (i_cmd)
                CMD_LOAD: begin
                    if (!i_cfg.enable || rst_n_step) begin
                        r_int   <= '0;
                        r_lerr  <= '0;
                        r_lrate <= '0;
                        r_lref  <= '0;
                        r_lmeas <= '0;
                    end
                    if (i_cfg.enable) r_ltime <= i_in_data.now_time;
                end
                CMD_INT_F: begin
                    if (!r_rst && (r_in.integrate_mode == MODE_FULL ||
                                   r_in.integrate_mode == MODE_WEIGHT))
                        r_int <= s50[47:0];
                end
                CMD_AW_E: begin
                    r_int <= r_ineg ? -$signed({6'b0, div_quo[41:0]})
                                    : $signed({6'b0, div_quo[41:0]});
                end
                CMD_OUT_A: begin
                    r_lerr  <= r_ek;
                    r_lrate <= r_d;
                    r_lref  <= r_r;
                    r_lmeas <= r_in.measurement;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind <= 1'b0;
        end else if (i_cmd == CMD_AW_D) begin
            r_wind <= wind_n;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= prod_n;
        case (i_cmd)
            CMD_LOAD: begin
                r_in  <= i_in_data;
                r_gap <= gap_n;
                r_rst <= rst_n_step;
                if (!i_cfg.enable) begin
                    r_st.drive     <= '0;
                    r_st.saturated <= 1'b0;
                    r_st.was_reset <= 1'b1;
                end
            end
            CMD_REF_B: r_acc <= r_prod;
            CMD_REF_C: r_r   <= r_rst ? r_in.reference : acc_sum[W_FRAC+31:W_FRAC];
            CMD_ERR:   r_e   <= e2[26:0];
            CMD_EK_A:  r_acc <= r_prod;
            CMD_EK_B:  r_ek  <= acc_sum[W_FRAC+26:W_FRAC];
            CMD_DNUM: begin
                r_nneg  <= num[33];
                r_nzero <= num == '0;
            end
            CMD_DRAW: begin
                if (!r_in.derivative_on_error && r_in.req_type == REQ_RATE)
                    r_raw <= raw_ext;
                else
                    r_raw <= raw_div;
            end
            CMD_D_A:   r_acc <= r_prod;
            CMD_D_B:   r_d   <= r_rst ? '0 : acc_sum[W_FRAC+26:W_FRAC];
            CMD_INT_B: r_inc <= r_prod[FRAC_BITS+43:FRAC_BITS];
            CMD_INT_D: r_acc <= r_prod;
            CMD_INT_E: r_incw <= s64[W_FRAC+43:W_FRAC];
            CMD_AW_A: begin
                r_ineg <= r_int[47];
                r_amag <= r_int[47] ? 48'(-r_int) : r_int;
            end
            CMD_AW_C:  r_acc <= r_prod;
            CMD_AW_D:  r_iterm <= r_ineg ? -$signed({1'b0, iterm_mag})
                                         : $signed({1'b0, iterm_mag});
            CMD_OUT_B: r_acc <= r_prod;
            CMD_OUT_C: begin
                r_st.was_reset <= r_rst;
                if (out_s > (MUL_P_W+1)'(32'sh7FFFFFFF)) begin
                    r_st.drive     <= 32'sh7FFFFFFF;
                    r_st.saturated <= 1'b1;
                end else if (out_s < -(MUL_P_W+1)'(33'sh080000000)) begin
                    r_st.drive     <= 32'sh80000000;
                    r_st.saturated <= 1'b1;
                end else begin
                    r_st.drive     <= out_s[31:0];
                    r_st.saturated <= 1'b0;
                end
            end
            CMD_FIN:   r_out <= r_st;
            default: ;
        endcase
    end

    assign o_status.enabled  = i_cfg.enable;
    assign o_status.div_done = div_done;
    assign o_status.wind     = r_wind;
    assign o_out_data        = r_out;

endmodule

// ===== design/fpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_ctrl: step sequencer
// Walks the datapath through one PID step and owns both handshakes.
// ----------------------------------------------------------------------------
module fpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  fpc_pkg::t_status i_status,
    output fpc_pkg::t_cmd    o_cmd
);
    import fpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_REF_A, S_REF_B, S_REF_C, S_ERR, S_EK_A, S_EK_B,
        S_DNUM, S_DWAIT, S_DRAW, S_D_A, S_D_B,
        S_INT_A, S_INT_B, S_INT_C, S_INT_D, S_INT_E, S_INT_F,
        S_AW_A, S_AW_B, S_AW_C, S_AW_D, S_AW_WAIT, S_AW_E,
        S_OUT_A, S_OUT_B, S_OUT_C, S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   fin_go;

    assign fin_go = !r_out_valid || i_out_ready;

    always_comb begin
        case (r_state)
            S_IDLE:  o_cmd = i_in_valid ? CMD_LOAD : CMD_NOP;
            S_REF_A: o_cmd = CMD_REF_A;
            S_REF_B: o_cmd = CMD_REF_B;
            S_REF_C: o_cmd = CMD_REF_C;
            S_ERR:   o_cmd = CMD_ERR;
            S_EK_A:  o_cmd = CMD_EK_A;
            S_EK_B:  o_cmd = CMD_EK_B;
            S_DNUM:  o_cmd = CMD_DNUM;
            S_DRAW:  o_cmd = CMD_DRAW;
            S_D_A:   o_cmd = CMD_D_A;
            S_D_B:   o_cmd = CMD_D_B;
            S_INT_A: o_cmd = CMD_INT_A;
            S_INT_B: o_cmd = CMD_INT_B;
            S_INT_C: o_cmd = CMD_INT_C;
            S_INT_D: o_cmd = CMD_INT_D;
            S_INT_E: o_cmd = CMD_INT_E;
            S_INT_F: o_cmd = CMD_INT_F;
            S_AW_A:  o_cmd = CMD_AW_A;
            S_AW_B:  o_cmd = CMD_AW_B;
            S_AW_C:  o_cmd = CMD_AW_C;
            S_AW_D:  o_cmd = CMD_AW_D;
            S_AW_E:  o_cmd = CMD_AW_E;
            S_OUT_A: o_cmd = CMD_OUT_A;
            S_OUT_B: o_cmd = CMD_OUT_B;
            S_OUT_C: o_cmd = CMD_OUT_C;
            S_FIN:   o_cmd = fin_go ? CMD_FIN : CMD_NOP;
            default: o_cmd = CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= i_status.enabled ? S_REF_A : S_FIN;
                end
                S_REF_A: r_state <= S_REF_B;
                S_REF_B: r_state <= S_REF_C;
                S_REF_C: r_state <= S_ERR;
                S_ERR:   r_state <= S_EK_A;
                S_EK_A:  r_state <= S_EK_B;
                S_EK_B:  r_state <= S_DNUM;
                S_DNUM:  r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (i_status.div_done) r_state <= S_DRAW;
                end
                S_DRAW:  r_state <= S_D_A;
                S_D_A:   r_state <= S_D_B;
                S_D_B:   r_state <= S_INT_A;
                S_INT_A: r_state <= S_INT_B;
                S_INT_B: r_state <= S_INT_C;
                S_INT_C: r_state <= S_INT_D;
                S_INT_D: r_state <= S_INT_E;
                S_INT_E: r_state <= S_INT_F;
                S_INT_F: r_state <= S_AW_A;
                S_AW_A:  r_state <= S_AW_B;
                S_AW_B:  r_state <= S_AW_C;
                S_AW_C:  r_state <= S_AW_D;
                S_AW_D:  r_state <= S_AW_WAIT;
                S_AW_WAIT: begin
                    if (!i_status.wind)         r_state <= S_OUT_A;
                    else if (i_status.div_done) r_state <= S_AW_E;
                end
                S_AW_E:  r_state <= S_OUT_A;
                S_OUT_A: r_state <= S_OUT_B;
                S_OUT_B: r_state <= S_OUT_C;
                S_OUT_C: r_state <= S_FIN;
                S_FIN: begin
                    if (fin_go) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/filtered_pid_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_pid_controller_top: PID step engine with smoothing and anti-windup
// The 48-bit bit-serial divider sets most of the step time; it runs once
// for the derivative and once more for anti-windup when the integral is
// clipped. The engine takes one beat at a time: a new beat is accepted
// only once the last step has finished, and a step waits at its end while
// the previous result is not yet taken; a disabled step skips the arithmetic.
// Reset: synchronous active-low i_rst_n clears config, history and state.
// ----------------------------------------------------------------------------
module filtered_pid_controller_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fpc_pkg::t_in_item  i_in_data,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fpc_pkg::t_out_item o_out_data,
    // APB configuration, 64-bit registers at 8-byte spacing
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import fpc_pkg::*;

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_status    status;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;

    // register writes complete in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_GAIN_P:  r_cfg.gain_p            <= pwdata[25:0];
                REG_GAIN_I:  r_cfg.gain_i            <= pwdata[22:0];
                REG_GAIN_D:  r_cfg.gain_d            <= pwdata[22:0];
                REG_I_LIMIT: r_cfg.integral_limit    <= pwdata[25:0];
                REG_E_LIMIT: r_cfg.error_limit       <= pwdata[25:0];
                REG_R_LIMIT: r_cfg.rate_limit        <= pwdata[25:0];
                REG_WEIGHTS: r_cfg.smoothing_weights <= pwdata;
                REG_ENABLE:  r_cfg.enable            <= pwdata[0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        case (reg_idx)
            REG_GAIN_P:  prdata = {38'b0, r_cfg.gain_p};
            REG_GAIN_I:  prdata = {41'b0, r_cfg.gain_i};
            REG_GAIN_D:  prdata = {41'b0, r_cfg.gain_d};
            REG_I_LIMIT: prdata = {38'b0, r_cfg.integral_limit};
            REG_E_LIMIT: prdata = {38'b0, r_cfg.error_limit};
            REG_R_LIMIT: prdata = {38'b0, r_cfg.rate_limit};
            REG_WEIGHTS: prdata = r_cfg.smoothing_weights;
            REG_ENABLE:  prdata = {63'b0, r_cfg.enable};
            default:     prdata = '0;
        endcase
    end

    // sequencer: handshakes and step order
    fpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic, history and result register
    fpc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

// ===== test/fpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_checker: drive prediction and result scoreboard
// Watches the APB writes, input beats and result beats of the filtered PID
// controller, runs its own copy of the step arithmetic per accepted beat and
// compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fpc_checker
    import fpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_psel,
    input  logic      i_penable,
    input  logic      i_pwrite,
    input  logic      i_pready,
    input  logic [5:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output int        o_errors,
    output int        o_pending
);

    localparam longint ONE = 32768;
    localparam longint INT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INT_LO = -64'sh0000_8000_0000_0000;

    t_cfg        cfg;
    longint      integ, prev_err, prev_rate, prev_ref, prev_meas;
    logic [31:0] prev_stamp;
    t_out_item   drive_q[$];

    function automatic longint wsel(int slot);
        longint w;
        w = longint'({48'd0, cfg.smoothing_weights[16*slot +: 16]});
        return (w > ONE) ? ONE : w;
    endfunction

    function automatic longint blend(longint w, longint old_v, longint cur);
        return (w * old_v + (ONE - w) * cur) >>> 15;
    endfunction

    function automatic longint clampm(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    // num / dt in Q16.16, magnitude truncated then clamped
    function automatic longint slope(longint num, longint unsigned dt, longint lim);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        if (mag == 0) return 0;
        if (dt == 0) q = lim;
        else q = (mag << FRAC_BITS) / dt;
        if (q > lim) q = lim;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void clear_history();
        integ = 0;
        prev_err = 0;
        prev_rate = 0;
        prev_ref = 0;
        prev_meas = 0;
    endfunction

    function automatic t_out_item pid_step(t_in_item it);
        t_out_item       res;
        longint          meas, refv, mrate, r, e, ek, d, raw, inc, iterm, sum;
        longint          elim, rlim, ilim, gi;
        longint unsigned gap, a, mag, st;
        logic [31:0]     g32;
        logic            rst, neg;
        meas = $signed(it.measurement);
        refv = $signed(it.reference);
        mrate = $signed(it.measured_rate);
        elim = longint'({38'd0, cfg.error_limit});
        rlim = longint'({38'd0, cfg.rate_limit});
        ilim = longint'({38'd0, cfg.integral_limit});
        gi = longint'({41'd0, cfg.gain_i});
        res = '0;
        if (!cfg.enable) begin
            clear_history();
            res.was_reset = 1'b1;
            return res;
        end
        g32 = it.now_time - prev_stamp;
        gap = {32'd0, g32};
        rst = gap > 2 * longint'({32'd0, it.nominal_period});
        if (rst) clear_history();
        prev_stamp = it.now_time;

        r = rst ? refv : blend(wsel(2), prev_ref, refv);
        e = r - meas;
        if (it.req_type == REQ_YAW) begin
            if (e > (longint'(180) << FRAC_BITS)) e -= longint'(360) << FRAC_BITS;
            if (e < -(longint'(180) << FRAC_BITS)) e += longint'(360) << FRAC_BITS;
        end
        e = clampm(e, elim);
        ek = blend(wsel(0), prev_err, e);

        if (rst) begin
            d = 0;
        end else begin
            if (it.derivative_on_error) raw = slope(ek - prev_err, gap, rlim);
            else if (it.req_type == REQ_RATE) raw = clampm(-mrate, rlim);
            else raw = slope(prev_meas - meas, gap, rlim);
            d = blend(wsel(1), prev_rate, raw);
        end

        if (!rst && (it.integrate_mode == MODE_FULL || it.integrate_mode == MODE_WEIGHT)) begin
            inc = (longint'(gap) * ek) >>> FRAC_BITS;
            if (it.integrate_mode == MODE_WEIGHT) inc = (inc * wsel(3)) >>> 15;
            integ += inc;
            if (integ > INT_HI) integ = INT_HI;
            if (integ < INT_LO) integ = INT_LO;
        end

        // anti-windup on the integral contribution
        neg = integ < 0;
        a = neg ? longint'(-integ) : longint'(integ);
        mag = (((a >> 24) * gi) << (24 - FRAC_BITS)) + (((a & 64'hFF_FFFF) * gi) >> FRAC_BITS);
        if (mag > ilim) begin
            st = (longint'(ilim) << FRAC_BITS) / gi;
            integ = neg ? -longint'(st) : longint'(st);
            mag = ilim;
        end
        iterm = neg ? -longint'(mag) : longint'(mag);

        prev_err = ek;
        prev_rate = d;
        prev_ref = r;
        prev_meas = meas;

        sum = ((longint'({38'd0, cfg.gain_p}) * ek + longint'({41'd0, cfg.gain_d}) * d)
               >>> FRAC_BITS) + iterm;
        if (sum > 64'sh7FFF_FFFF) begin
            sum = 64'sh7FFF_FFFF;
            res.saturated = 1'b1;
        end
        if (sum < -64'sh8000_0000) begin
            sum = -64'sh8000_0000;
            res.saturated = 1'b1;
        end
        res.drive = sum[31:0];
        res.was_reset = rst;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_beat;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg = '0;
            clear_history();
            prev_stamp = '0;
            drive_q.delete();
            o_errors <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[5:3])
                    REG_GAIN_P:  cfg.gain_p = i_pwdata[25:0];
                    REG_GAIN_I:  cfg.gain_i = i_pwdata[22:0];
                    REG_GAIN_D:  cfg.gain_d = i_pwdata[22:0];
                    REG_I_LIMIT: cfg.integral_limit = i_pwdata[25:0];
                    REG_E_LIMIT: cfg.error_limit = i_pwdata[25:0];
                    REG_R_LIMIT: cfg.rate_limit = i_pwdata[25:0];
                    REG_WEIGHTS: cfg.smoothing_weights = i_pwdata;
                    REG_ENABLE:  cfg.enable = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) drive_q.push_back(pid_step(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (drive_q.size() == 0) begin
                    $error("result beat with no prediction pending: drive %h", i_out_data.drive);
                    errs++;
                end else begin
                    exp_beat = drive_q.pop_front();
                    if (i_out_data.drive !== exp_beat.drive) begin
                        $error("drive: expected %0d, got %0d", exp_beat.drive, i_out_data.drive);
                        errs++;
                    end
                    if (i_out_data.saturated !== exp_beat.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               exp_beat.saturated, i_out_data.saturated);
                        errs++;
                    end
                    if (i_out_data.was_reset !== exp_beat.was_reset) begin
                        $error("was_reset: expected %0b, got %0b",
                               exp_beat.was_reset, i_out_data.was_reset);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
        o_pending <= drive_q.size();
    end

endmodule

// ===== test/tb_filtered_pid_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_filtered_pid_controller_top: stimulus and verdict for the PID engine
// Programs the registers over APB in several phases (defaults, typical,
// extremes, zero limits, random), sends directed corner beats and then
// randomized time-stamped control sequences with random idling on both
// sides. Prediction and comparison live in fpc_checker.
// ----------------------------------------------------------------------------
module tb_filtered_pid_controller_top;
    import fpc_pkg::*;

    localparam int  RUN_ITEMS   = 950;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = 200;    // beyond the worst step latency
    localparam int  HOLD_CYCLES = 800;    // long receiver stall

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    int          cycles = 0;
    bit          hold_req = 0;     // asks the receiver for one long stall
    bit          burst = 0;        // stretches with no idling
    logic [31:0] stamp = '0;       // running timestamp of the control loop
    logic [31:0] period = 32'h0000_1000;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    filtered_pid_controller_top dut (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_ready, .i_in_data,
        .o_out_valid, .i_out_ready, .o_out_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    fpc_checker checker_u (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_data(o_out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(mismatches), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // setup cycle, then access cycle; the register is written at the
    // edge that ends the access cycle
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // only between phases: every predicted beat back, then the engine drained
    task automatic wait_idle();
        while (pending != 0 || i_in_valid) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // style: 0 typical random, 1 large fixed values, 2 zero limits, 3 full random
    task automatic program_regs(int style, bit en);
        logic [63:0] w;
        case (style)
            1: begin
                reg_write(REG_GAIN_P, 64'd65536000);
                reg_write(REG_GAIN_I, 64'd6553600);
                reg_write(REG_GAIN_D, 64'd6553600);
                reg_write(REG_I_LIMIT, 64'd65536000);
                reg_write(REG_E_LIMIT, 64'd65536000);
                reg_write(REG_R_LIMIT, 64'd65536000);
                reg_write(REG_WEIGHTS, 64'hFFFF_8000_FFFF_8000);
            end
            2: begin
                reg_write(REG_GAIN_P, $urandom_range(0, 65536 * 4));
                reg_write(REG_GAIN_I, 64'd0);
                reg_write(REG_GAIN_D, $urandom_range(0, 65536 * 4));
                reg_write(REG_I_LIMIT, 64'd0);
                reg_write(REG_E_LIMIT, 64'd0);
                reg_write(REG_R_LIMIT, 64'd0);
                reg_write(REG_WEIGHTS, 64'd0);
            end
            3: begin
                w = {$urandom, $urandom};
                reg_write(REG_GAIN_P, {$urandom, $urandom});
                reg_write(REG_GAIN_I, {$urandom, $urandom});
                reg_write(REG_GAIN_D, {$urandom, $urandom});
                reg_write(REG_I_LIMIT, $urandom_range(0, 65536000));
                reg_write(REG_E_LIMIT, $urandom_range(0, 65536000));
                reg_write(REG_R_LIMIT, $urandom_range(0, 65536000));
                reg_write(REG_WEIGHTS, w);
            end
            default: begin
                w = {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                     16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768))};
                reg_write(REG_GAIN_P, $urandom_range(0, 65536 * 8));
                reg_write(REG_GAIN_I, $urandom_range(0, 65536 * 2));
                reg_write(REG_GAIN_D, $urandom_range(0, 65536 / 4));
                reg_write(REG_I_LIMIT, $urandom_range(65536, 65536 * 200));
                reg_write(REG_E_LIMIT, $urandom_range(65536, 65536 * 300));
                reg_write(REG_R_LIMIT, $urandom_range(65536, 65536 * 500));
                reg_write(REG_WEIGHTS, w);
            end
        endcase
        reg_write(REG_ENABLE, {63'd0, en});
    endtask

    // one beat: optional idle gap, then hold valid until accepted.
    // Called and returns at a rising edge.
    task automatic send_beat(t_in_item it);
        int gap;
        gap = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        stamp = it.now_time;
    endtask

    function automatic t_in_item make_beat(bit noise);
        t_in_item it;
        int       pick;
        it.req_type = 2'($urandom_range(0, 3));
        it.integrate_mode = 2'($urandom_range(0, 3));
        it.derivative_on_error = 1'($urandom);
        if (noise) begin
            it.measurement = $urandom;
            it.reference = $urandom;
            it.measured_rate = $urandom;
            it.nominal_period = $urandom;
            it.now_time = $urandom_range(0, 1) ? $urandom : stamp + $urandom_range(0, 65536);
            return it;
        end
        // well-formed loop step: mostly on time, some late, some repeated
        it.measurement = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
        it.reference = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
        it.measured_rate = $signed($urandom_range(0, 100 << 16)) - (50 << 16);
        it.nominal_period = period;
        pick = $urandom_range(0, 99);
        if (pick < 5) it.now_time = stamp;
        else if (pick < 10) it.now_time = stamp + 3 * period + $urandom_range(1, 1000);
        else it.now_time = stamp + $urandom_range(period / 2, 2 * period);
        return it;
    endfunction

    // directed corner beats
    task automatic directed_run();
        t_in_item it;
        for (int k = 0; k < 20; k++) begin
            it = make_beat(0);
            it.req_type = 2'(k % 4);
            it.integrate_mode = 2'((k / 4) % 4);
            it.derivative_on_error = k[0];
            case (k)
                1: begin it.measurement = 32'sh7FFF_FFFF; it.reference = 32'sh8000_0000; end
                2: begin it.measurement = 32'sh8000_0000; it.reference = 32'sh7FFF_FFFF; end
                3: it.measured_rate = 32'sh8000_0000;
                4: it.now_time = stamp;                       // zero gap
                5: it.now_time = stamp - 32'd5;               // time went backwards
                6: begin it.nominal_period = '0; it.now_time = stamp; end
                7: it.nominal_period = 32'hFFFF_FFFF;
                // yaw wrap both ways
                9: begin
                    it.req_type = REQ_YAW;
                    it.reference = 32'sd170 <<< 16;
                    it.measurement = -(32'sd170 <<< 16);
                end
                13: begin
                    it.req_type = REQ_YAW;
                    it.reference = -(32'sd170 <<< 16);
                    it.measurement = 32'sd170 <<< 16;
                end
                14: begin it.req_type = REQ_RATE; it.measured_rate = 32'sh7FFF_FFFF; end
                default: ;
            endcase
            send_beat(it);
        end
    endtask

    // receiver: random stalls, stretches of none, one long hold-off
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(negedge i_clk);
            while (!o_out_valid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    initial begin
        int per_phase;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: disabled, every beat clears history
        for (int k = 0; k < 4; k++) send_beat(make_beat(k[0]));
        i_in_valid <= 1'b0;
        wait_idle();

        program_regs(0, 1'b1);
        directed_run();
        i_in_valid <= 1'b0;
        wait_idle();

        per_phase = RUN_ITEMS / 6;
        for (int ph = 0; ph < 6; ph++) begin
            program_regs(ph % 4, ph != 4 || $urandom_range(0, 1));
            period = (ph == 5) ? $urandom : $urandom_range(16, 32'h0002_0000);
            for (int k = 0; k < per_phase; k++) begin
                if (k % 40 == 0) burst = ($urandom_range(0, 3) == 0);
                if (ph == 1 && k == 20) hold_req = 1;
                send_beat(make_beat($urandom_range(0, 99) < 15));
            end
            i_in_valid <= 1'b0;
            burst = 0;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
